### design/crcwg_pkg.sv
package crcwg_pkg;

    localparam int DATA_W = 64;
    localparam int REM_W  = 32;
    localparam int LEN_W  = 6;
    localparam int ADDR_W = 4;
    localparam int APB_W  = 32;

    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_CHECK    = 1'b1
    } op_t;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_POLY      = 2'd0,
        REG_DEGREE    = 2'd1,
        REG_WORD_BITS = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    localparam logic [REM_W-1:0] POLY_RESET      = 32'h04C1_1DB7;
    localparam logic [LEN_W-1:0] DEGREE_RESET    = 6'd32;
    localparam logic [LEN_W-1:0] WORD_BITS_RESET = 6'd32;

    // Low n bits set; n of 64 gives all ones
    function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W:0] n);
        low_mask = ~({DATA_W{1'b1}} << n);
    endfunction

endpackage

### design/crc_word_generate_check.sv
// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------
// item in   start / busy         op, bits, valid_bits
// result    done (1-cycle)       codeword, remainder, check_ok
// config    APB psel/penable     paddr, pwdata, prdata, pready
//
// One transaction per cycle; busy is never raised.
// From accept to done a transaction passes the input register, the
// alignment stage, one stage per 8 data bits of the division and the
// result register.
// rst_n resets the configuration registers, clears all stage valid flags.
// The receiver cannot stall: each result shows for exactly one cycle.
module crc_word_generate_check #(
    parameter int MAX_WORD   = 32,
    parameter int MAX_DEGREE = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  crcwg_pkg::op_t                    op,
    input  logic [crcwg_pkg::DATA_W-1:0]      bits,
    input  logic [crcwg_pkg::LEN_W-1:0]       valid_bits,
    output logic                              done,
    output logic [crcwg_pkg::DATA_W-1:0]      codeword,
    output logic [crcwg_pkg::REM_W-1:0]       remainder,
    output logic                              check_ok,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcwg_pkg::ADDR_W-1:0]      paddr,
    input  logic [crcwg_pkg::APB_W-1:0]       pwdata,
    output logic [crcwg_pkg::APB_W-1:0]       prdata,
    output logic                              pready
);
    import crcwg_pkg::*;

    localparam int STEPS      = 8;
    localparam int NUM_STAGES = (MAX_WORD + STEPS - 1) / STEPS;
    localparam int PAD_W      = NUM_STAGES * STEPS;
    localparam int LATENCY    = NUM_STAGES + 3;

    // ---------------- configuration ----------------
    logic [REM_W-1:0] poly_reg;
    logic [LEN_W-1:0] degree_reg;
    logic [LEN_W-1:0] word_bits_reg;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            degree_reg    <= DEGREE_RESET;
            word_bits_reg <= WORD_BITS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_POLY:      poly_reg      <= pwdata;
                REG_DEGREE:    degree_reg    <= pwdata[LEN_W-1:0];
                REG_WORD_BITS: word_bits_reg <= pwdata[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_POLY:      prdata = poly_reg;
            REG_DEGREE:    prdata = APB_W'(degree_reg);
            REG_WORD_BITS: prdata = APB_W'(word_bits_reg);
            default:       prdata = '0;
        endcase
    end

    // Effective lengths: zero reads as one, oversize clamps to the maximum
    logic [LEN_W-1:0]      deg_eff;
    logic [LEN_W-1:0]      wb_eff;
    logic [LEN_W-1:0]      align_sh;
    logic [MAX_DEGREE-1:0] poly_left;

    always_comb
    begin
        if (degree_reg == '0)
            deg_eff = LEN_W'(1);
        else if (degree_reg > LEN_W'(MAX_DEGREE))
            deg_eff = LEN_W'(MAX_DEGREE);
        else
            deg_eff = degree_reg;

        if (word_bits_reg == '0)
            wb_eff = LEN_W'(1);
        else if (word_bits_reg > LEN_W'(MAX_WORD))
            wb_eff = LEN_W'(MAX_WORD);
        else
            wb_eff = word_bits_reg;
    end

    // The division register is held left-aligned at bit MAX_DEGREE-1
    assign align_sh  = LEN_W'(MAX_DEGREE) - deg_eff;
    assign poly_left = poly_reg[MAX_DEGREE-1:0] << align_sh;

    // ---------------- input register ----------------
    logic              in_v_reg;
    op_t               in_op_reg;
    logic [DATA_W-1:0] in_bits_reg;
    logic [LEN_W-1:0]  in_vb_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_op_reg   <= op;
            in_bits_reg <= bits;
            in_vb_reg   <= valid_bits;
        end
    end

    // ---------------- alignment ----------------
    // Split the message into the high part A (fed through the divider)
    // and the low part B (xored onto the result): M mod P = A*x^d mod P ^ B
    logic [DATA_W-1:0]     word_gen;
    logic [DATA_W-1:0]     cw_chk;
    logic [LEN_W:0]        clear_n;
    logic [PAD_W-1:0]      a_next;
    logic [MAX_DEGREE-1:0] b_next;
    logic [DATA_W-1:0]     cw_next;

    always_comb
    begin
        word_gen = in_bits_reg & low_mask({1'b0, wb_eff});
        clear_n  = {1'b0, wb_eff} - {1'b0, in_vb_reg};
        if (in_vb_reg < wb_eff)
            word_gen = word_gen & ~low_mask(clear_n);
        cw_chk = in_bits_reg & low_mask({1'b0, wb_eff} + {1'b0, deg_eff});

        if (in_op_reg == OP_CHECK)
        begin
            a_next  = PAD_W'(cw_chk >> deg_eff);
            b_next  = MAX_DEGREE'(cw_chk & low_mask({1'b0, deg_eff}));
            cw_next = cw_chk;
        end
        else
        begin
            a_next  = PAD_W'(word_gen);
            b_next  = '0;
            cw_next = word_gen << deg_eff;
        end
    end

    // ---------------- division pipeline ----------------
    logic                  v_reg   [0:NUM_STAGES];
    op_t                   op_reg  [0:NUM_STAGES];
    logic [PAD_W-1:0]      a_reg   [0:NUM_STAGES];
    logic [MAX_DEGREE-1:0] b_reg   [0:NUM_STAGES];
    logic [DATA_W-1:0]     cw_reg  [0:NUM_STAGES];
    logic [MAX_DEGREE-1:0] crc_reg [0:NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_v_reg)
        begin
            op_reg[0]  <= in_op_reg;
            a_reg[0]   <= a_next;
            b_reg[0]   <= b_next;
            cw_reg[0]  <= cw_next;
            crc_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        logic [MAX_DEGREE-1:0] crc_next;
        logic [STEPS-1:0]      chunk;

        assign chunk = a_reg[s][PAD_W-1-STEPS*s -: STEPS];

        // Advance eight message bits, most significant first
        always_comb
        begin
            crc_next = crc_reg[s];
            for (int k = STEPS - 1; k >= 0; k--)
            begin
                if (crc_next[MAX_DEGREE-1] ^ chunk[k])
                    crc_next = (crc_next << 1) ^ poly_left;
                else
                    crc_next = crc_next << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (v_reg[s])
            begin
                op_reg[s+1]  <= op_reg[s];
                a_reg[s+1]   <= a_reg[s];
                b_reg[s+1]   <= b_reg[s];
                cw_reg[s+1]  <= cw_reg[s];
                crc_reg[s+1] <= crc_next;
            end
        end
    end

    // ---------------- result register ----------------
    logic [MAX_DEGREE-1:0] rem_final;
    logic                  done_reg;
    logic [DATA_W-1:0]     codeword_reg;
    logic [REM_W-1:0]      remainder_reg;
    logic                  check_ok_reg;

    assign rem_final = (crc_reg[NUM_STAGES] >> align_sh) ^ b_reg[NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_reg[NUM_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[NUM_STAGES])
        begin
            remainder_reg <= REM_W'(rem_final);
            if (op_reg[NUM_STAGES] == OP_CHECK)
            begin
                codeword_reg <= cw_reg[NUM_STAGES];
                check_ok_reg <= (rem_final == '0);
            end
            else
            begin
                codeword_reg <= cw_reg[NUM_STAGES] | DATA_W'(rem_final);
                check_ok_reg <= 1'b0;
            end
        end
    end

    assign done      = done_reg;
    assign codeword  = codeword_reg;
    assign remainder = remainder_reg;
    assign check_ok  = check_ok_reg;

    // ---------------- assertions ----------------
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted transaction did not complete on time");

    a_ok_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && check_ok |-> remainder == '0)
        else $error("check_ok with nonzero remainder");

    a_rem_width : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (remainder >> deg_eff) == '0)
        else $error("remainder wider than degree");

    a_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NUM_STAGES] |=> !done)
        else $error("result strobe without a transaction in flight");

endmodule
